// ----- sv/pmt_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet tracker.
package pmt_pkg;

	localparam int COORD_W = 12;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = COORD_W;

	localparam logic [7:0] SYNC_MASK = 8'h08;
	localparam logic [7:0] OVF_MASK  = 8'hC0;

	localparam logic [COORD_W-1:0] START_X = COORD_W'(400);
	localparam logic [COORD_W-1:0] START_Y = COORD_W'(300);
	localparam logic [COORD_W-1:0] RIGHT_MARGIN  = COORD_W'(2);
	localparam logic [COORD_W-1:0] BOTTOM_MARGIN = COORD_W'(3);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] CFG_ENABLE      = 3'd0;
	localparam logic [IDX_W-1:0] CFG_WHEEL_MODE  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SENSITIVITY = 3'd2;
	localparam logic [IDX_W-1:0] CFG_WIDTH       = 3'd3;
	localparam logic [IDX_W-1:0] CFG_HEIGHT      = 3'd4;

	localparam logic [3:0] SENS_MIN   = 4'd1;
	localparam logic [3:0] SENS_MAX   = 4'd10;
	localparam logic [3:0] SENS_RESET = 4'd4;
	localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(800);
	localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(600);

	typedef enum logic [1:0] {
		ST_MOVE     = 2'd0,
		ST_RESYNC   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// One classified packet handed from the assembler to the executor.
	typedef struct packed {
		logic       resync;
		logic [7:0] flags;
		logic [7:0] raw_x;
		logic [7:0] raw_y;
		logic [7:0] wheel;
	} pkt_t;

	// Settings the executor works with.
	typedef struct packed {
		logic [3:0]         sens;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
	} back_cfg_t;

	// One result transaction.
	typedef struct packed {
		status_t            status;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [2:0]         buttons;
		logic [2:0]         prev_buttons;
		logic [7:0]         wheel_delta;
		logic               moved;
	} res_t;

endpackage

// ----- sv/pmt_front.sv -----
// Byte assembler: collects packet bytes, realigns on a missing sync bit, classifies packets.
module pmt_front import pmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] byte_data,
	input  logic       enable,
	input  logic       wheel_mode,
	output logic       pkt_push,
	output pkt_t       pkt
);

	logic [7:0] bytes_q [4];
	logic [2:0] fill_q;

	logic [7:0] b [4];
	logic [7:0] nb [4];
	logic [2:0] size;
	logic [2:0] nf;
	logic [2:0] fill_d;
	logic [1:0] idx;
	logic       complete;
	logic       found;
	logic [1:0] shift;

	// View of the packet with the new byte written in.
	always_comb begin
		idx  = fill_q[1:0];
		size = wheel_mode ? 3'd4 : 3'd3;
		nf   = fill_q + 3'd1;
		for (int k = 0; k < 4; k++) begin
			b[k] = (idx == 2'(k)) ? byte_data : bytes_q[k];
		end
		complete = (nf >= size);
	end

	// Search for the first later byte carrying the sync bit.
	always_comb begin
		found = 1'b0;
		shift = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (!found && (3'(i) < size) && ((b[i] & SYNC_MASK) != 8'h00)) begin
				found = 1'b1;
				shift = 2'(i);
			end
		end
	end

	// Next store contents and fill count.
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			nb[j] = b[j];
		end
		fill_d = nf;
		if (complete) begin
			if ((b[0] & SYNC_MASK) != 8'h00) begin
				fill_d = 3'd0;
			end else if (found) begin
				for (int j = 0; j < 3; j++) begin
					if ((3'(j) + {1'b0, shift}) < size) begin
						nb[j] = b[2'(j) + shift];
					end
				end
				fill_d = size - {1'b0, shift};
			end else begin
				fill_d = 3'd0;
			end
		end
	end

	// Packet handed to the queue.
	always_comb begin
		pkt_push   = byte_valid && enable && complete;
		pkt.resync = (b[0] & SYNC_MASK) == 8'h00;
		pkt.flags  = b[0];
		pkt.raw_x  = b[1];
		pkt.raw_y  = b[2];
		pkt.wheel  = wheel_mode ? b[3] : 8'h00;
	end

	// Fill count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
		end else if (byte_valid && enable) begin
			fill_q <= fill_d;
		end
	end

	// Packet byte store, no reset needed.
	always_ff @(posedge clk) begin
		if (byte_valid && enable) begin
			for (int k = 0; k < 4; k++) begin
				bytes_q[k] <= nb[k];
			end
		end
	end

endmodule

// ----- sv/pmt_pkt_queue.sv -----
// Two-entry queue of classified packets between the assembler and the executor.
module pmt_pkt_queue import pmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  pkt_t wr_data,
	input  logic rd_en,
	output logic rd_valid,
	output pkt_t rd_data,
	output logic full
);

	pkt_t       mem_q [2];
	logic [1:0] count_q;
	logic       wptr_q;
	logic       rptr_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
		end else begin
			if (do_wr) wptr_q <= ~wptr_q;
			if (do_rd) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ----- sv/pmt_back.sv -----
// Packet executor: updates buttons and cursor, and queues result transactions.
module pmt_back import pmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pkt_valid,
	input  pkt_t      pkt,
	output logic      pkt_pop,
	input  back_cfg_t cfg,
	output logic      res_empty,
	output res_t      res,
	input  logic      res_pop
);

	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;
	logic [2:0]         btn_q;
	logic [2:0]         last_btn_q;

	res_t       out_q [2];
	logic [1:0] out_cnt_q;
	logic       out_wptr_q;
	logic       out_rptr_q;
	logic       out_rd;
	logic       out_room;

	logic signed [12:0]    px, py, tx, ty, dx, dy;
	logic signed [COORD_W+2:0] nx, ny, max_x, max_y;
	logic [COORD_W-1:0]    cx, cy;
	logic                  ovf;
	res_t                  r;

	// Output queue handshake.
	assign res_empty = (out_cnt_q == 2'd0);
	assign res       = out_q[out_rptr_q];
	assign out_rd    = res_pop && !res_empty;
	assign out_room  = (out_cnt_q != 2'd2) || out_rd;
	assign pkt_pop   = pkt_valid && out_room;

	// Scaled deltas, truncated toward zero; Y is inverted.
	always_comb begin
		px = $signed(pkt.raw_x) * $signed({1'b0, cfg.sens});
		py = $signed(pkt.raw_y) * $signed({1'b0, cfg.sens});
		tx = px + $signed({12'd0, px[12]});
		ty = py + $signed({12'd0, py[12]});
		dx = tx >>> 1;
		dy = ty >>> 1;
		nx = $signed({3'b000, cur_x_q}) + (COORD_W+3)'(dx);
		ny = $signed({3'b000, cur_y_q}) - (COORD_W+3)'(dy);
		max_x = $signed({3'b000, cfg.width}) - $signed({3'b000, RIGHT_MARGIN});
		max_y = $signed({3'b000, cfg.height}) - $signed({3'b000, BOTTOM_MARGIN});
		if (max_x < 0) max_x = '0;
		if (max_y < 0) max_y = '0;
		if (nx < 0)          cx = '0;
		else if (nx > max_x) cx = max_x[COORD_W-1:0];
		else                 cx = nx[COORD_W-1:0];
		if (ny < 0)          cy = '0;
		else if (ny > max_y) cy = max_y[COORD_W-1:0];
		else                 cy = ny[COORD_W-1:0];
	end

	// Result of the packet at the head of the queue.
	always_comb begin
		ovf = (pkt.flags & OVF_MASK) != 8'h00;
		r.pos_x        = cur_x_q;
		r.pos_y        = cur_y_q;
		r.buttons      = btn_q;
		r.prev_buttons = last_btn_q;
		r.wheel_delta  = 8'h00;
		r.moved        = 1'b0;
		if (pkt.resync) begin
			r.status = ST_RESYNC;
		end else begin
			r.buttons      = pkt.flags[2:0];
			r.prev_buttons = btn_q;
			r.wheel_delta  = pkt.wheel;
			if (ovf) begin
				r.status = ST_OVERFLOW;
			end else begin
				r.status = ST_MOVE;
				r.pos_x  = cx;
				r.pos_y  = cy;
				r.moved  = (cx != cur_x_q) || (cy != cur_y_q);
			end
		end
	end

	// Tracker state and output queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= START_X;
			cur_y_q    <= START_Y;
			btn_q      <= 3'd0;
			last_btn_q <= 3'd0;
			out_cnt_q  <= 2'd0;
			out_wptr_q <= 1'b0;
			out_rptr_q <= 1'b0;
		end else begin
			if (pkt_pop) begin
				cur_x_q    <= r.pos_x;
				cur_y_q    <= r.pos_y;
				btn_q      <= r.buttons;
				last_btn_q <= r.prev_buttons;
				out_wptr_q <= ~out_wptr_q;
			end
			if (out_rd) out_rptr_q <= ~out_rptr_q;
			out_cnt_q <= out_cnt_q + {1'b0, pkt_pop} - {1'b0, out_rd};
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (pkt_pop) begin
			out_q[out_wptr_q] <= r;
		end
	end

endmodule

// ----- sv/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: configuration registers and the two halves.
//
//   channel   handshake        payload
//   -------   ---------        -------
//   input     push / full      data_byte
//   result    empty / pop      status, pos_x, pos_y, buttons, prev_buttons,
//                              wheel_delta, moved
//   config    cfg_we           cfg_index, cfg_data
//
// One byte is taken every cycle while full is low; the assembler classifies it in the
// cycle it arrives. A complete packet enters the packet queue at the edge that takes
// its last byte. The executor finishes one packet per cycle while its two-entry result
// queue has room, and writes each result there. full rises only when the two-entry
// packet queue is full, which happens when results are not popped. Reset clears all
// control state and loads the defaults.
module ps2_mouse_packet_tracker import pmt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic [COORD_W-1:0] pos_x,
	output logic [COORD_W-1:0] pos_y,
	output logic [2:0]         buttons,
	output logic [2:0]         prev_buttons,
	output logic signed [7:0]  wheel_delta,
	output logic               moved,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]  cfg_data
);

	logic               enable_q;
	logic               wheel_q;
	logic [3:0]         sens_q;
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;

	logic      in_acc;
	logic      pkt_push;
	pkt_t      pkt_in;
	logic      pkt_valid;
	pkt_t      pkt_head;
	logic      pkt_pop;
	back_cfg_t bcfg;
	res_t      res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wheel_q  <= 1'b0;
			sens_q   <= SENS_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:     enable_q <= cfg_data[0];
				CFG_WHEEL_MODE: wheel_q  <= cfg_data[0];
				CFG_SENSITIVITY: begin
					if (cfg_data >= DATA_W'(SENS_MIN) && cfg_data <= DATA_W'(SENS_MAX)) begin
						sens_q <= cfg_data[3:0];
					end
				end
				CFG_WIDTH:      width_q  <= cfg_data[COORD_W-1:0];
				CFG_HEIGHT:     height_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_acc = push && !full;

	pmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_acc),
		.byte_data  (data_byte),
		.enable     (enable_q),
		.wheel_mode (wheel_q),
		.pkt_push   (pkt_push),
		.pkt        (pkt_in)
	);

	pmt_pkt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (pkt_push),
		.wr_data  (pkt_in),
		.rd_en    (pkt_pop),
		.rd_valid (pkt_valid),
		.rd_data  (pkt_head),
		.full     (full)
	);

	assign bcfg.sens   = sens_q;
	assign bcfg.width  = width_q;
	assign bcfg.height = height_q;

	pmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt       (pkt_head),
		.pkt_pop   (pkt_pop),
		.cfg       (bcfg),
		.res_empty (empty),
		.res       (res),
		.res_pop   (pop)
	);

	// Result fields.
	assign status       = res.status;
	assign pos_x        = res.pos_x;
	assign pos_y        = res.pos_y;
	assign buttons      = res.buttons;
	assign prev_buttons = res.prev_buttons;
	assign wheel_delta  = $signed(res.wheel_delta);
	assign moved        = res.moved;

endmodule
